[src/iarg_pkg.sv]
`timescale 1ns / 1ps
// iarg_pkg: sizes, payload types and helpers for the index argsort block
// depends on nothing; used by iarg_ram users and index_argsort
package iarg_pkg;

    // list depth and stored key width
    localparam int DEPTH     = 64;
    localparam int KEY_WIDTH = 32;

    // fixed field widths
    localparam int SLOT_W = 6;
    localparam int KEY_IN_W = 32;

    // address width of the stores and width of the list count
    localparam int IA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // input operation codes
    localparam logic OP_KEY    = 1'b0;
    localparam logic OP_APPEND = 1'b1;

    typedef struct packed {
        logic                       op;
        logic [SLOT_W-1:0]          slot;
        logic signed [KEY_IN_W-1:0] key;
        logic                       last;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] sorted_index;
        logic              last_out;
    } out_item_t;

    // key store address of a slot, wrapping at the store depth
    function automatic logic [IA_W-1:0] key_addr(input logic [SLOT_W-1:0] slot);
        key_addr = IA_W'(32'(slot) % DEPTH);
    endfunction

endpackage

[src/iarg_ram.sv]
`timescale 1ns / 1ps
// iarg_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module iarg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/index_argsort.sv]
`timescale 1ns / 1ps
// index_argsort: indirect sort of a loaded index list by stored keys
// depends on iarg_pkg and iarg_ram
//
// usage:
//   s_ channel takes one item per handshake. op key writes item.key into the
//   key store at item.slot; op append adds item.slot to the index list. An
//   append with last set starts the sort of the whole list (an append to a
//   full list is dropped, but its last flag still starts the sort).
//   cfg channel writes sort_descending (cfg_ready is always high): 0 sorts
//   ascending, 1 descending. Equal keys keep their load order.
//   m_ channel returns the sorted entries, one per item, last_out on the final.
// timing:
//   key writes and plain appends are accepted while idle. Sorting is a stable
//   insertion sort on one shared signed comparator, reading both stores one
//   word per cycle: each entry and its key are fetched (ST_RD_I, ST_RD_IKEY,
//   ST_GET_K), each lower entry is read, compared and shifted up (ST_RD_PREV,
//   ST_RD_PKEY, ST_CMP), then the entry is placed (ST_PLACE). Each result is
//   read (ST_OUT_RD) and held (ST_OUT_WAIT) until m_ready is seen.
//   s_ready is low from the start of a sort until the final result is taken.
// reset: list emptied and ascending order selected; the stores are not cleared.
// stall: a held result stays on m_item until m_ready is seen.
module index_argsort (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  iarg_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output iarg_pkg::out_item_t  m_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_RD_I     = 10'b00_0000_0010,
        ST_RD_IKEY  = 10'b00_0000_0100,
        ST_GET_K    = 10'b00_0000_1000,
        ST_RD_PREV  = 10'b00_0001_0000,
        ST_RD_PKEY  = 10'b00_0010_0000,
        ST_CMP      = 10'b00_0100_0000,
        ST_PLACE    = 10'b00_1000_0000,
        ST_OUT_RD   = 10'b01_0000_0000,
        ST_OUT_WAIT = 10'b10_0000_0000
    } state_t;

    state_t                               state_reg, state_next;
    logic                                 desc_reg;
    logic [iarg_pkg::CNT_W-1:0]           count_reg, count_next;
    logic [iarg_pkg::CNT_W-1:0]           i_reg, i_next;
    logic [iarg_pkg::CNT_W-1:0]           j_reg, j_next;
    logic [iarg_pkg::SLOT_W-1:0]          entry_reg, entry_next;
    logic [iarg_pkg::SLOT_W-1:0]          prev_reg, prev_next;
    logic [iarg_pkg::KEY_WIDTH-1:0]       k_reg, k_next;

    // store ports
    logic                                 key_we, key_re;
    logic [iarg_pkg::IA_W-1:0]            key_waddr, key_raddr;
    logic [iarg_pkg::KEY_WIDTH-1:0]       key_wdata, key_rdata;
    logic                                 idx_we, idx_re;
    logic [iarg_pkg::IA_W-1:0]            idx_waddr, idx_raddr;
    logic [iarg_pkg::SLOT_W-1:0]          idx_wdata, idx_rdata;

    logic                                 s_fire;
    logic                                 m_fire;
    logic                                 key_before;
    logic [iarg_pkg::KEY_WIDTH-1:0]       cmp_a, cmp_b;
    logic [iarg_pkg::CNT_W-1:0]           count_app;
    logic                                 list_full;

    iarg_ram #(
        .WIDTH (iarg_pkg::KEY_WIDTH),
        .DEPTH (iarg_pkg::DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    iarg_ram #(
        .WIDTH (iarg_pkg::SLOT_W),
        .DEPTH (iarg_pkg::DEPTH)
    ) u_idx_ram (
        .aclk  (aclk),
        .we    (idx_we),
        .waddr (idx_waddr),
        .wdata (idx_wdata),
        .re    (idx_re),
        .raddr (idx_raddr),
        .rdata (idx_rdata)
    );

    // handshakes
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = (state_reg == ST_OUT_WAIT);
    assign m_fire    = m_valid && m_ready;
    assign cfg_ready = 1'b1;

    // result fields straight from the held list read
    assign m_item.sorted_index = idx_rdata;
    assign m_item.last_out     = (i_reg + iarg_pkg::CNT_W'(1) == count_reg);

    // shared comparator: swapping operands turns less-than into greater-than
    assign cmp_a      = desc_reg ? key_rdata : k_reg;
    assign cmp_b      = desc_reg ? k_reg : key_rdata;
    assign key_before = ($signed(cmp_a) < $signed(cmp_b));

    // list count after an append
    assign list_full = (count_reg == iarg_pkg::CNT_W'(iarg_pkg::DEPTH));
    assign count_app = list_full ? count_reg : count_reg + iarg_pkg::CNT_W'(1);

    // sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        entry_next = entry_reg;
        prev_next  = prev_reg;
        k_next     = k_reg;
        key_we     = 1'b0;
        key_waddr  = iarg_pkg::key_addr(s_item.slot);
        key_wdata  = iarg_pkg::KEY_WIDTH'($unsigned(s_item.key));
        key_re     = 1'b0;
        key_raddr  = iarg_pkg::key_addr(idx_rdata);
        idx_we     = 1'b0;
        idx_waddr  = count_reg[iarg_pkg::IA_W-1:0];
        idx_wdata  = s_item.slot;
        idx_re     = 1'b0;
        idx_raddr  = i_reg[iarg_pkg::IA_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_item.op == iarg_pkg::OP_KEY) begin
                        key_we = 1'b1;
                    end else begin
                        idx_we     = !list_full;
                        count_next = count_app;
                        if (s_item.last) begin
                            i_next = iarg_pkg::CNT_W'(1);
                            if (count_app <= iarg_pkg::CNT_W'(1)) begin
                                i_next     = '0;
                                state_next = ST_OUT_RD;
                            end else begin
                                state_next = ST_RD_I;
                            end
                        end
                    end
                end
            end
            // fetch the entry to insert
            ST_RD_I: begin
                idx_re     = 1'b1;
                state_next = ST_RD_IKEY;
            end
            ST_RD_IKEY: begin
                entry_next = idx_rdata;
                key_re     = 1'b1;
                j_next     = i_reg;
                state_next = ST_GET_K;
            end
            ST_GET_K: begin
                k_next     = key_rdata;
                state_next = ST_RD_PREV;
            end
            // look at the entry below the hole
            ST_RD_PREV: begin
                if (j_reg == '0) begin
                    state_next = ST_PLACE;
                end else begin
                    idx_re     = 1'b1;
                    idx_raddr  = iarg_pkg::IA_W'(j_reg - iarg_pkg::CNT_W'(1));
                    state_next = ST_RD_PKEY;
                end
            end
            ST_RD_PKEY: begin
                prev_next  = idx_rdata;
                key_re     = 1'b1;
                state_next = ST_CMP;
            end
            // shift the lower entry up while the new key goes strictly first
            ST_CMP: begin
                if (key_before) begin
                    idx_we     = 1'b1;
                    idx_waddr  = j_reg[iarg_pkg::IA_W-1:0];
                    idx_wdata  = prev_reg;
                    j_next     = j_reg - iarg_pkg::CNT_W'(1);
                    state_next = ST_RD_PREV;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                idx_we    = 1'b1;
                idx_waddr = j_reg[iarg_pkg::IA_W-1:0];
                idx_wdata = entry_reg;
                if (i_reg + iarg_pkg::CNT_W'(1) == count_reg) begin
                    i_next     = '0;
                    state_next = ST_OUT_RD;
                end else begin
                    i_next     = i_reg + iarg_pkg::CNT_W'(1);
                    state_next = ST_RD_I;
                end
            end
            // stream the sorted list out
            ST_OUT_RD: begin
                idx_re     = 1'b1;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (m_fire) begin
                    if (m_item.last_out) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_reg + iarg_pkg::CNT_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            desc_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                desc_reg <= cfg_data;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        entry_reg <= entry_next;
        prev_reg  <= prev_next;
        k_reg     <= k_next;
    end

    // checks
    a_ready_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while a result is shown");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= iarg_pkg::CNT_W'(iarg_pkg::DEPTH))
        else $error("list count beyond depth");

    a_final_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_item.last_out |=> (count_reg == '0) && s_ready)
        else $error("list not emptied after final result");

    a_shift_steps_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) && key_before |=>
            (j_reg == $past(j_reg) - iarg_pkg::CNT_W'(1)) && (state_reg == ST_RD_PREV))
        else $error("insertion hole did not move down");

    a_out_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (i_reg < count_reg))
        else $error("result index past list end");

endmodule
